@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/ssei_pkg.sv @@
// ---------------------------------------------------------------------------
// Sequence event interpreter package
// Types, codes and small helper functions shared by the interpreter modules.
// ---------------------------------------------------------------------------
package ssei_pkg;

	localparam int LVL_W          = 5;
	localparam int LOOP_DEPTH_DEF = 8;
	localparam int CALL_DEPTH_DEF = 8;

	localparam logic [6:0] VEL_RESET = 7'd100;

	// Result kinds
	localparam logic [4:0] KIND_NOTE      = 5'd0;
	localparam logic [4:0] KIND_TIE       = 5'd1;
	localparam logic [4:0] KIND_REST      = 5'd2;
	localparam logic [4:0] KIND_WAIT      = 5'd3;
	localparam logic [4:0] KIND_VOLUME    = 5'd4;
	localparam logic [4:0] KIND_MASTER    = 5'd5;
	localparam logic [4:0] KIND_TRANSPOSE = 5'd6;
	localparam logic [4:0] KIND_PROGRAM   = 5'd7;
	localparam logic [4:0] KIND_PAN       = 5'd8;
	localparam logic [4:0] KIND_ADSR      = 5'd9;
	localparam logic [4:0] KIND_OCTAVE    = 5'd10;
	localparam logic [4:0] KIND_ECHO_VOL  = 5'd11;
	localparam logic [4:0] KIND_DSP_WRITE = 5'd12;
	localparam logic [4:0] KIND_FADE      = 5'd13;
	localparam logic [4:0] KIND_NOISE     = 5'd14;
	localparam logic [4:0] KIND_DUR_RATE  = 5'd15;
	localparam logic [4:0] KIND_DEF_LEN   = 5'd16;
	localparam logic [4:0] KIND_LOOP_BEG  = 5'd17;
	localparam logic [4:0] KIND_LOOP_END  = 5'd18;
	localparam logic [4:0] KIND_CALL      = 5'd19;
	localparam logic [4:0] KIND_RETURN    = 5'd20;
	localparam logic [4:0] KIND_JUMP      = 5'd21;
	localparam logic [4:0] KIND_SKIPPED   = 5'd22;
	localparam logic [4:0] KIND_END       = 5'd23;
	localparam logic [4:0] KIND_INVALID   = 5'd24;

	// Stop codes
	localparam logic [1:0] STOP_CONT    = 2'd0;
	localparam logic [1:0] STOP_END     = 2'd1;
	localparam logic [1:0] STOP_STACK   = 2'd2;
	localparam logic [1:0] STOP_UNKNOWN = 2'd3;

	// Status bytes of the extended command set
	localparam logic [7:0] OP_TRANSPOSE = 8'hE4;
	localparam logic [7:0] OP_MASTER    = 8'hE5;
	localparam logic [7:0] OP_ECHO_VOL  = 8'hE6;
	localparam logic [7:0] OP_OCT_DOWN  = 8'hE7;
	localparam logic [7:0] OP_OCT_UP    = 8'hE8;
	localparam logic [7:0] OP_LOOP_BEG  = 8'hEA;
	localparam logic [7:0] OP_LOOP_END  = 8'hEB;
	localparam logic [7:0] OP_DUR_RATE  = 8'hEC;
	localparam logic [7:0] OP_DSP_WRITE = 8'hED;
	localparam logic [7:0] OP_SKIP3     = 8'hEF;
	localparam logic [7:0] OP_NOISE     = 8'hF0;
	localparam logic [7:0] OP_VOLUME    = 8'hF1;
	localparam logic [7:0] OP_FADE      = 8'hF3;
	localparam logic [7:0] OP_PAN       = 8'hF4;
	localparam logic [7:0] OP_ADSR      = 8'hF7;
	localparam logic [7:0] OP_RETURN    = 8'hF8;
	localparam logic [7:0] OP_CALL      = 8'hF9;
	localparam logic [7:0] OP_JUMP      = 8'hFA;
	localparam logic [7:0] OP_SKIP2     = 8'hFB;
	localparam logic [7:0] OP_PROGRAM   = 8'hFC;
	localparam logic [7:0] OP_DEF_LEN   = 8'hFD;
	localparam logic [7:0] OP_SKIP1     = 8'hFE;
	localparam logic [7:0] OP_END       = 8'hFF;

	localparam logic [7:0] SLUR_MARK = 8'hFE;
	localparam logic [7:0] KEY_NONE  = 8'hFF;
	localparam logic [7:0] CNT_IDLE  = 8'hFF;

	typedef struct packed {
		logic [15:0] event_addr;
		logic [7:0]  status;
		logic [7:0]  byte_one;
		logic [7:0]  byte_two;
		logic [7:0]  byte_three;
	} item_t;

	typedef struct packed {
		logic [4:0]  kind;
		logic [7:0]  note_key;
		logic [6:0]  velocity;
		logic [7:0]  gate_duration;
		logic [7:0]  delta_time;
		logic [15:0] value_main;
		logic [7:0]  value_second;
		logic [15:0] next_addr;
		logic [1:0]  stop_code;
	} result_t;

	typedef struct packed {
		logic [7:0]  octave;
		logic [7:0]  default_length;
		logic [7:0]  duration_rate;
		logic [7:0]  instrument;
		logic [15:0] envelope_word;
		logic [7:0]  pan_raw;
		logic [7:0]  previous_key;
		logic        slur_pending;
	} chan_t;

	localparam chan_t CHAN_RESET = '{
		octave:         8'd4,
		default_length: 8'd1,
		duration_rate:  8'd8,
		instrument:     8'd0,
		envelope_word:  16'h8fe0,
		pan_raw:        8'd0,
		previous_key:   KEY_NONE,
		slur_pending:   1'b0
	};

	// What the decoder sees of the two stacks
	typedef struct packed {
		logic [LVL_W-1:0] loop_level;
		logic [7:0]       loop_cnt;
		logic [LVL_W-1:0] call_level;
		logic [15:0]      ret_addr;
	} stk_view_t;

	// Stack updates requested by the decoder
	typedef struct packed {
		logic        loop_dec;
		logic        loop_inc;
		logic        loop_wr;
		logic [7:0]  loop_wr_data;
		logic        call_push;
		logic        call_pop;
		logic [15:0] call_wr_data;
	} stk_cmd_t;

	function automatic logic [7:0] key_offset(input logic [3:0] k);
		logic [7:0] r;
		case (k)
			4'd0:    r = 8'h0c;
			4'd1:    r = 8'h0e;
			4'd2:    r = 8'h10;
			4'd3:    r = 8'h11;
			4'd4:    r = 8'h13;
			4'd5:    r = 8'h15;
			4'd6:    r = 8'h17;
			4'd8:    r = 8'h0d;
			4'd9:    r = 8'h0f;
			4'd10:   r = 8'h10;
			4'd11:   r = 8'h12;
			4'd12:   r = 8'h14;
			4'd13:   r = 8'h16;
			4'd14:   r = 8'h17;
			default: r = 8'h6f;
		endcase
		return r;
	endfunction

	// Magnitude of an eight-bit two's complement value; -128 gives 128.
	function automatic logic [7:0] sabs8(input logic [7:0] b);
		return b[7] ? 8'(~b + 8'd1) : b;
	endfunction

endpackage

@@ src/ssei_stack.sv @@
// ---------------------------------------------------------------------------
// Loop and call stacks
// Loop counter stack (grows downwards) and return address stack.
// ---------------------------------------------------------------------------
module ssei_stack #(
	parameter int LOOP_DEPTH = ssei_pkg::LOOP_DEPTH_DEF,
	parameter int CALL_DEPTH = ssei_pkg::CALL_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                upd,
	input  ssei_pkg::stk_cmd_t  cmd,
	output ssei_pkg::stk_view_t view
);
	import ssei_pkg::*;

	localparam int LI = (LOOP_DEPTH > 1) ? $clog2(LOOP_DEPTH) : 1;
	localparam int CI = (CALL_DEPTH > 1) ? $clog2(CALL_DEPTH) : 1;

	logic [LVL_W-1:0] loop_level_q;
	logic [LVL_W-1:0] call_level_q;
	logic [7:0]       loop_cnt_q [LOOP_DEPTH];
	logic [15:0]      ret_q      [CALL_DEPTH];
	logic [LVL_W-1:0] ret_level;
	logic             loop_in_range;

	assign loop_in_range = loop_level_q < LVL_W'(LOOP_DEPTH);
	assign ret_level     = call_level_q - LVL_W'(1);

	assign view.loop_level = loop_level_q;
	assign view.call_level = call_level_q;
	assign view.loop_cnt   = loop_in_range ? loop_cnt_q[loop_level_q[LI-1:0]] : CNT_IDLE;
	assign view.ret_addr   = ret_q[ret_level[CI-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_level_q <= LVL_W'(LOOP_DEPTH);
			call_level_q <= '0;
			for (int i = 0; i < LOOP_DEPTH; i++) begin
				loop_cnt_q[i] <= CNT_IDLE;
			end
		end else if (upd) begin
			if (cmd.loop_wr && loop_in_range) begin
				loop_cnt_q[loop_level_q[LI-1:0]] <= cmd.loop_wr_data;
			end
			if (cmd.loop_dec) begin
				loop_level_q <= loop_level_q - LVL_W'(1);
			end else if (cmd.loop_inc) begin
				loop_level_q <= loop_level_q + LVL_W'(1);
			end
			if (cmd.call_push) begin
				call_level_q <= call_level_q + LVL_W'(1);
			end else if (cmd.call_pop) begin
				call_level_q <= ret_level;
			end
		end
	end

	// Return addresses are only read after a call has written them.
	always_ff @(posedge clk) begin
		if (upd && cmd.call_push) begin
			ret_q[call_level_q[CI-1:0]] <= cmd.call_wr_data;
		end
	end

endmodule

@@ src/ssei_decode.sv @@
// ---------------------------------------------------------------------------
// Event decoder
// Decodes one event against the channel state and produces its result,
// the next channel state and the stack updates.
// ---------------------------------------------------------------------------
module ssei_decode #(
	parameter int LOOP_DEPTH = ssei_pkg::LOOP_DEPTH_DEF,
	parameter int CALL_DEPTH = ssei_pkg::CALL_DEPTH_DEF
) (
	input  ssei_pkg::item_t     item,
	input  ssei_pkg::chan_t     chan,
	input  ssei_pkg::stk_view_t view,
	input  logic [6:0]          note_velocity,
	output ssei_pkg::result_t   res,
	output ssei_pkg::chan_t     chan_nxt,
	output ssei_pkg::stk_cmd_t  cmd
);
	import ssei_pkg::*;

	logic [15:0] addr;
	logic        long_form;
	logic [7:0]  len;
	logic [7:0]  look;
	logic [16:0] after;
	logic [3:0]  rate;
	logic [11:0] prod;
	logic [7:0]  scaled;
	logic [7:0]  gate;
	logic [3:0]  k;
	logic [7:0]  key;
	logic [15:0] rel;
	logic [15:0] dest;
	logic [8:0]  vol_sum;
	logic [7:0]  vol_clamp;
	logic [7:0]  abs_one;
	logic [7:0]  pan_clamp;
	logic [7:0]  cnt_dec;

	assign addr      = item.event_addr;
	assign long_form = item.status[4];
	assign len       = long_form ? item.byte_one : chan.default_length;
	assign look      = long_form ? item.byte_two : item.byte_one;
	assign after     = {1'b0, addr} + (long_form ? 17'd2 : 17'd1);
	assign rate      = (chan.duration_rate < 8'd8) ? chan.duration_rate[3:0] : 4'd8;
	assign prod      = len * rate;
	assign scaled    = prod[10:3];
	assign k         = item.status[3:0];

	// Gate is the scaled length, capped at one tick short of the length and never below one.
	always_comb begin
		if (len == 8'd0) begin
			gate = 8'd1;
		end else begin
			gate = (scaled > len - 8'd1) ? len - 8'd1 : scaled;
			if (gate == 8'd0) begin
				gate = 8'd1;
			end
		end
	end

	assign key = {chan.octave[4:0], 3'b000} + {chan.octave[5:0], 2'b00} + key_offset(k);

	assign rel     = {item.byte_two, item.byte_one} + addr;
	assign dest    = {item.byte_three, item.byte_two} + addr;
	assign vol_sum = {1'b0, sabs8(item.byte_one)} + {1'b0, sabs8(item.byte_two)};
	assign vol_clamp = vol_sum[8] ? 8'hFF : vol_sum[7:0];
	assign abs_one   = sabs8(item.byte_one);

	// Pan is clamped to -15..15 as a signed byte.
	always_comb begin
		if (item.byte_one[7] && item.byte_one < 8'hF1) begin
			pan_clamp = 8'hF1;
		end else if (!item.byte_one[7] && item.byte_one > 8'h0F) begin
			pan_clamp = 8'h0F;
		end else begin
			pan_clamp = item.byte_one;
		end
	end

	// An inactive counter takes its count from the event; zero wraps round.
	always_comb begin
		if (view.loop_cnt == 8'd0) begin
			cnt_dec = 8'd0;
		end else if (view.loop_cnt[7]) begin
			cnt_dec = item.byte_one - 8'd1;
		end else begin
			cnt_dec = view.loop_cnt - 8'd1;
		end
	end

	always_comb begin
		res           = '0;
		res.kind      = KIND_INVALID;
		res.next_addr = addr + 16'd1;
		chan_nxt      = chan;
		cmd           = '0;

		if (!item.status[7]) begin
			res.delta_time = len;
			res.next_addr  = after[15:0];
			if (k == 4'd7) begin
				res.kind              = KIND_REST;
				chan_nxt.previous_key = KEY_NONE;
			end else if (k == 4'd15) begin
				res.kind              = KIND_WAIT;
				chan_nxt.previous_key = KEY_NONE;
			end else begin
				res.note_key      = key;
				res.gate_duration = gate;
				if (chan.slur_pending && key == chan.previous_key) begin
					res.kind = KIND_TIE;
				end else begin
					res.kind     = KIND_NOTE;
					res.velocity = note_velocity;
				end
				chan_nxt.previous_key = key;
			end
			chan_nxt.slur_pending = !after[16] && look == SLUR_MARK;
		end else if (item.status[7:4] == 4'h8) begin
			res.kind       = KIND_VOLUME;
			res.value_main = {12'd0, item.status[3:0]};
		end else if (item.status[7:4] == 4'h9) begin
			res.kind        = KIND_OCTAVE;
			chan_nxt.octave = {4'd0, item.status[3:0]};
			res.value_main  = {12'd0, item.status[3:0]};
		end else begin
			case (item.status)
				OP_TRANSPOSE: begin
					res.kind       = KIND_TRANSPOSE;
					res.value_main = {8'd0, item.byte_one};
					res.next_addr  = addr + 16'd2;
				end
				OP_MASTER: begin
					res.kind       = KIND_MASTER;
					res.value_main = {9'd0, vol_clamp[7:1]};
					res.next_addr  = addr + 16'd3;
				end
				OP_ECHO_VOL: begin
					res.kind         = KIND_ECHO_VOL;
					res.value_main   = {8'd0, item.byte_one};
					res.value_second = item.byte_two;
					res.next_addr    = addr + 16'd3;
				end
				OP_OCT_DOWN: begin
					res.kind        = KIND_OCTAVE;
					chan_nxt.octave = chan.octave - 8'd1;
					res.value_main  = {8'd0, chan_nxt.octave};
				end
				OP_OCT_UP: begin
					res.kind        = KIND_OCTAVE;
					chan_nxt.octave = chan.octave + 8'd1;
					res.value_main  = {8'd0, chan_nxt.octave};
				end
				OP_LOOP_BEG: begin
					res.kind = KIND_LOOP_BEG;
					if (view.loop_level == '0) begin
						res.stop_code = STOP_STACK;
					end else begin
						cmd.loop_dec = 1'b1;
					end
				end
				OP_LOOP_END: begin
					res.kind       = KIND_LOOP_END;
					res.value_main = {8'd0, item.byte_one};
					res.next_addr  = addr + 16'd4;
					if (view.loop_level >= LVL_W'(LOOP_DEPTH)) begin
						res.stop_code = STOP_STACK;
					end else if (cnt_dec != 8'd0) begin
						cmd.loop_wr      = 1'b1;
						cmd.loop_wr_data = cnt_dec;
						res.next_addr    = dest;
					end else begin
						cmd.loop_wr      = 1'b1;
						cmd.loop_wr_data = CNT_IDLE;
						cmd.loop_inc     = 1'b1;
					end
				end
				OP_DUR_RATE: begin
					res.kind               = KIND_DUR_RATE;
					chan_nxt.duration_rate = item.byte_one;
					res.value_main         = {8'd0, item.byte_one};
					res.next_addr          = addr + 16'd2;
				end
				OP_DSP_WRITE: begin
					res.kind         = KIND_DSP_WRITE;
					res.value_main   = {8'd0, item.byte_one};
					res.value_second = item.byte_two;
					res.next_addr    = addr + 16'd3;
				end
				OP_SKIP3: begin
					res.kind      = KIND_SKIPPED;
					res.next_addr = addr + 16'd3;
				end
				OP_NOISE: begin
					res.kind = KIND_NOISE;
				end
				OP_VOLUME: begin
					res.kind       = KIND_VOLUME;
					res.value_main = {8'd0, abs_one[7] ? 8'd127 : abs_one};
					res.next_addr  = addr + 16'd2;
				end
				OP_FADE: begin
					res.kind       = KIND_FADE;
					res.value_main = {8'd0, item.byte_one};
					res.next_addr  = addr + 16'd2;
				end
				OP_PAN: begin
					res.kind         = KIND_PAN;
					chan_nxt.pan_raw = item.byte_one;
					res.value_main   = {8'd0, pan_clamp};
					res.next_addr    = addr + 16'd2;
				end
				OP_ADSR: begin
					res.kind               = KIND_ADSR;
					chan_nxt.envelope_word = {item.byte_two, item.byte_one};
					res.value_main         = {item.byte_two, item.byte_one};
					res.next_addr          = addr + 16'd3;
				end
				OP_RETURN: begin
					res.kind = KIND_RETURN;
					if (view.call_level == '0) begin
						res.stop_code = STOP_STACK;
					end else begin
						cmd.call_pop  = 1'b1;
						res.next_addr = view.ret_addr;
					end
				end
				OP_CALL: begin
					res.kind       = KIND_CALL;
					res.value_main = rel;
					res.next_addr  = addr + 16'd3;
					if (view.call_level >= LVL_W'(CALL_DEPTH)) begin
						res.stop_code = STOP_STACK;
					end else begin
						cmd.call_push    = 1'b1;
						cmd.call_wr_data = addr + 16'd3;
						res.next_addr    = rel;
					end
				end
				OP_JUMP: begin
					res.kind       = KIND_JUMP;
					res.value_main = rel;
					res.next_addr  = rel;
				end
				OP_SKIP2: begin
					res.kind      = KIND_SKIPPED;
					res.next_addr = addr + 16'd2;
				end
				OP_PROGRAM: begin
					res.kind            = KIND_PROGRAM;
					chan_nxt.instrument = item.byte_one;
					res.value_main      = {8'd0, item.byte_one};
					res.next_addr       = addr + 16'd2;
				end
				OP_DEF_LEN: begin
					res.kind                = KIND_DEF_LEN;
					chan_nxt.default_length = item.byte_one;
					res.value_main          = {8'd0, item.byte_one};
					res.next_addr           = addr + 16'd2;
				end
				OP_SKIP1: begin
					res.kind = KIND_SKIPPED;
				end
				OP_END: begin
					res.kind      = KIND_END;
					res.stop_code = STOP_END;
				end
				default: begin
					res.kind      = KIND_INVALID;
					res.stop_code = STOP_UNKNOWN;
				end
			endcase
		end
	end

endmodule

@@ src/sound_sequence_event_interpreter_unit.sv @@
// ---------------------------------------------------------------------------
// Sound sequence event interpreter
// An accepted request is registered in item_s1; its decoded result is registered in res_s2.
// Throughput: one request per cycle while the output is not stalled; decode and state update take one stage.
// Reset: channel state, stacks and note velocity return to their start values.
// ---------------------------------------------------------------------------
module sound_sequence_event_interpreter_unit #(
	parameter int LOOP_DEPTH = ssei_pkg::LOOP_DEPTH_DEF,
	parameter int CALL_DEPTH = ssei_pkg::CALL_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [6:0]        cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [15:0]       event_addr,
	input  logic [7:0]        status,
	input  logic [7:0]        byte_one,
	input  logic [7:0]        byte_two,
	input  logic [7:0]        byte_three,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [4:0]        kind,
	output logic signed [7:0] note_key,
	output logic [6:0]        velocity,
	output logic [7:0]        gate_duration,
	output logic [7:0]        delta_time,
	output logic [15:0]       value_main,
	output logic [7:0]        value_second,
	output logic [15:0]       next_addr,
	output logic [1:0]        stop_code
);
	import ssei_pkg::*;

	item_t     item_s1;
	logic      valid_s1;
	result_t   res_s2;
	logic      valid_s2;
	chan_t     chan_q;
	chan_t     chan_nxt;
	logic [6:0] note_velocity_q;
	result_t   res_d;
	stk_view_t stk_view;
	stk_cmd_t  stk_cmd;
	logic      advance;
	logic      fire;
	logic      accept;

	// The result register frees up whenever it is empty or being taken.
	assign advance   = !valid_s2 || !out_stall;
	assign fire      = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	ssei_decode #(
		.LOOP_DEPTH (LOOP_DEPTH),
		.CALL_DEPTH (CALL_DEPTH)
	) u_decode (
		.item          (item_s1),
		.chan          (chan_q),
		.view          (stk_view),
		.note_velocity (note_velocity_q),
		.res           (res_d),
		.chan_nxt      (chan_nxt),
		.cmd           (stk_cmd)
	);

	ssei_stack #(
		.LOOP_DEPTH (LOOP_DEPTH),
		.CALL_DEPTH (CALL_DEPTH)
	) u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (fire),
		.cmd    (stk_cmd),
		.view   (stk_view)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1        <= 1'b0;
			valid_s2        <= 1'b0;
			chan_q          <= CHAN_RESET;
			note_velocity_q <= VEL_RESET;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (fire) begin
				chan_q <= chan_nxt;
			end
			if (cfg_valid && cfg_ready) begin
				note_velocity_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{event_addr: event_addr, status: status, byte_one: byte_one,
				byte_two: byte_two, byte_three: byte_three};
		end
		if (fire) begin
			res_s2 <= res_d;
		end
	end

	assign out_valid     = valid_s2;
	assign kind          = res_s2.kind;
	assign note_key      = $signed(res_s2.note_key);
	assign velocity      = res_s2.velocity;
	assign gate_duration = res_s2.gate_duration;
	assign delta_time    = res_s2.delta_time;
	assign value_main    = res_s2.value_main;
	assign value_second  = res_s2.value_second;
	assign next_addr     = res_s2.next_addr;
	assign stop_code     = res_s2.stop_code;

`include "assert_macros.svh"

	`ASSERT_SAME(a_stack_fault_kind, out_valid && stop_code == STOP_STACK, kind == KIND_LOOP_BEG || kind == KIND_LOOP_END || kind == KIND_CALL || kind == KIND_RETURN, "stack fault on a kind that has no stack")
	`ASSERT_SAME(a_end_stop, out_valid && kind == KIND_END, stop_code == STOP_END, "end of track without its stop code")
	`ASSERT_NEXT(a_call_push, fire && res_d.kind == KIND_CALL && res_d.stop_code == STOP_CONT, stk_view.call_level == $past(stk_view.call_level) + LVL_W'(1), "call did not push the return stack")
	`ASSERT_NEXT(a_loop_bound, 1'b1, stk_view.loop_level <= LVL_W'(LOOP_DEPTH), "loop level beyond stack depth")

endmodule
